// ----- src/h3pi_pkg.sv -----
package h3pi_pkg;

   localparam int COORD_W          = 21;
   localparam int INDEX_W          = 63;
   localparam int LEVEL_W          = 5;
   localparam int MAX_BITS_DEFAULT = 21;
   localparam logic [LEVEL_W-1:0] LEVELS_RESET = 5'd21;

   typedef struct packed {
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
   } point_type;

   typedef struct packed {
      logic [INDEX_W-1:0] hilbert_index;
      logic               range_error;
   } index_type;

   // Control that travels alongside each word through the chain of cells.
   typedef struct packed {
      logic       valid;
      logic       range_error;
      logic [2:0] entry;
      logic [1:0] dir;
   } ctl_type;

   // Rotate right within 3 bits by (dir + 1) mod 3.
   function automatic logic [2:0] rotr3(input logic [2:0] v, input logic [1:0] dir);
      logic [2:0] r;
      case (dir)
         2'd0:    r = {v[0], v[2:1]};
         2'd1:    r = {v[1:0], v[2]};
         default: r = v;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] gray_inv3(input logic [2:0] g);
      return g ^ {1'b0, g[2:1]} ^ {2'b00, g[2]};
   endfunction

   function automatic logic [2:0] entry_tab(input logic [2:0] w);
      logic [2:0] r;
      case (w)
         3'd0, 3'd1: r = 3'd0;
         3'd2, 3'd3: r = 3'd3;
         3'd4, 3'd5: r = 3'd6;
         default:    r = 3'd5;
      endcase
      return r;
   endfunction

   // New direction: (dir + D[w] + 1) mod 3, with D = {0,1,1,2,2,1,1,3}.
   function automatic logic [1:0] dir_next(input logic [1:0] dir, input logic [2:0] w);
      logic [1:0] dt;
      logic [2:0] s;
      logic [1:0] r;
      case (w)
         3'd0:             dt = 2'd0;
         3'd1, 3'd2:       dt = 2'd1;
         3'd3, 3'd4:       dt = 2'd2;
         3'd5, 3'd6:       dt = 2'd1;
         default:          dt = 2'd3;
      endcase
      s = 3'(dir) + 3'(dt) + 3'd1;
      case (s)
         3'd0, 3'd3, 3'd6: r = 2'd0;
         3'd1, 3'd4, 3'd7: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

// ----- src/hilbert3d_point_to_index.sv -----
// 3D Hilbert index encoder. A point is taken on any cycle that start is high
// (busy never rises), so one point per clock is sustained; its index passes the
// input register and one cell per coordinate bit level, then leaves with
// rsp_valid high for exactly one cycle. The receiver cannot stall the block, so
// it must take every word as it appears. A coordinate at or above 2^bits_per_axis
// gives index zero with range_error set. The user must write bits_per_axis
// through the csr port only while no points are in flight; the block does not
// enforce this. Zero counts as one level and values above MAX_BITS saturate.
module hilbert3d_point_to_index #(
   parameter int MAX_BITS = h3pi_pkg::MAX_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  h3pi_pkg::point_type           req_point,
   output logic                          rsp_valid,
   output h3pi_pkg::index_type           rsp_result,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [h3pi_pkg::LEVEL_W-1:0]  csr_data
);

   localparam logic [h3pi_pkg::LEVEL_W-1:0] MAX_LEVELS = h3pi_pkg::LEVEL_W'(MAX_BITS);

   logic [h3pi_pkg::LEVEL_W-1:0] levels_ff;
   logic [h3pi_pkg::LEVEL_W-1:0] levels_used;
   logic                         out_of_range;

   h3pi_pkg::ctl_type     ctl_chain [0:MAX_BITS];
   logic [MAX_BITS-1:0]   x_chain   [0:MAX_BITS];
   logic [MAX_BITS-1:0]   y_chain   [0:MAX_BITS];
   logic [MAX_BITS-1:0]   z_chain   [0:MAX_BITS];
   logic [3*MAX_BITS-1:0] h_chain   [0:MAX_BITS];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= h3pi_pkg::LEVELS_RESET;
      end else if (csr_valid && csr_ready) begin
         levels_ff <= csr_data;
      end
   end

   always_comb begin
      levels_used = levels_ff;
      if (levels_ff == '0) begin
         levels_used = h3pi_pkg::LEVEL_W'(1);
      end else if (levels_ff > MAX_LEVELS) begin
         levels_used = MAX_LEVELS;
      end
   end

   assign out_of_range = ((req_point.coord_x >> levels_used) != '0) ||
                         ((req_point.coord_y >> levels_used) != '0) ||
                         ((req_point.coord_z >> levels_used) != '0);

   // Input register heading the chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_chain[0].valid <= 1'b0;
      end else begin
         ctl_chain[0].valid <= start && !busy;
      end
      ctl_chain[0].range_error <= out_of_range;
      ctl_chain[0].entry       <= 3'd0;
      ctl_chain[0].dir         <= 2'd0;
      x_chain[0]               <= req_point.coord_x[MAX_BITS-1:0];
      y_chain[0]               <= req_point.coord_y[MAX_BITS-1:0];
      z_chain[0]               <= req_point.coord_z[MAX_BITS-1:0];
   end

   assign h_chain[0] = '0;

   // Cell k handles coordinate bit MAX_BITS-1-k, most significant first.
   for (genvar k = 0; k < MAX_BITS; k++) begin : g_cell
      h3pi_cell #(
         .MAX_BITS (MAX_BITS),
         .LEVEL    (MAX_BITS - 1 - k)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .levels (levels_used),
         .ctl_up (ctl_chain[k]),
         .x_up   (x_chain[k]),
         .y_up   (y_chain[k]),
         .z_up   (z_chain[k]),
         .h_up   (h_chain[k]),
         .ctl_ff (ctl_chain[k+1]),
         .x_ff   (x_chain[k+1]),
         .y_ff   (y_chain[k+1]),
         .z_ff   (z_chain[k+1]),
         .h_ff   (h_chain[k+1])
      );
   end

   assign rsp_valid                = ctl_chain[MAX_BITS].valid;
   assign rsp_result.range_error   = ctl_chain[MAX_BITS].range_error;
   assign rsp_result.hilbert_index = ctl_chain[MAX_BITS].range_error ? '0 :
                                     h3pi_pkg::INDEX_W'(h_chain[MAX_BITS]);

endmodule

// ----- src/h3pi_cell.sv -----
module h3pi_cell #(
   parameter int MAX_BITS = h3pi_pkg::MAX_BITS_DEFAULT,
   parameter int LEVEL    = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [h3pi_pkg::LEVEL_W-1:0]   levels,
   input  h3pi_pkg::ctl_type              ctl_up,
   input  logic [MAX_BITS-1:0]            x_up,
   input  logic [MAX_BITS-1:0]            y_up,
   input  logic [MAX_BITS-1:0]            z_up,
   input  logic [3*MAX_BITS-1:0]          h_up,
   output h3pi_pkg::ctl_type              ctl_ff,
   output logic [MAX_BITS-1:0]            x_ff,
   output logic [MAX_BITS-1:0]            y_ff,
   output logic [MAX_BITS-1:0]            z_ff,
   output logic [3*MAX_BITS-1:0]          h_ff
);

   localparam logic [h3pi_pkg::LEVEL_W-1:0] THIS_LEVEL = h3pi_pkg::LEVEL_W'(LEVEL);

   h3pi_pkg::ctl_type     ctl_in;
   logic [3*MAX_BITS-1:0] h_in;
   logic [2:0]            oct;
   logic [2:0]            w;
   logic                  active;

   // A cell only takes part when its bit lies below the configured level count.
   assign active = THIS_LEVEL < levels;
   assign oct    = {z_up[LEVEL], y_up[LEVEL], x_up[LEVEL]};
   assign w      = h3pi_pkg::gray_inv3(h3pi_pkg::rotr3(oct ^ ctl_up.entry, ctl_up.dir));

   always_comb begin
      ctl_in = ctl_up;
      h_in   = h_up;
      if (active) begin
         h_in         = {h_up[3*MAX_BITS-4:0], w};
         ctl_in.entry = ctl_up.entry ^ h3pi_pkg::rotr3(h3pi_pkg::entry_tab(w), ctl_up.dir);
         ctl_in.dir   = h3pi_pkg::dir_next(ctl_up.dir, w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.range_error <= ctl_in.range_error;
      ctl_ff.entry       <= ctl_in.entry;
      ctl_ff.dir         <= ctl_in.dir;
      x_ff               <= x_up;
      y_ff               <= y_up;
      z_ff               <= z_up;
      h_ff               <= h_in;
   end

endmodule
